/* rtl/spc_pkg.sv */
// Shared types, constants and register indexes of the speed PI controller.
package spc_pkg;

   localparam int unsigned FRAC_BITS_DFLT   = 16;
   localparam int unsigned QUEUE_DEPTH_DFLT = 4;

   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned ERROR_W  = SPEED_W + 1;
   localparam int unsigned GAIN_W   = 32;
   localparam int unsigned IBOUND_W = 31;
   localparam int unsigned DBOUND_W = 15;
   localparam int unsigned SUM_W    = 32;
   localparam int unsigned CMD_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDFWD_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_BOUND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_BOUND  = 3'd4;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] feedfwd_gain;
      logic [IBOUND_W-1:0]      integ_bound;
      logic [DBOUND_W-1:0]      drive_bound;
   } cfg_type;

   // one classified item as it sits in the queue
   typedef struct packed {
      logic                      stop;
      logic signed [SPEED_W-1:0] target;
      logic signed [ERROR_W-1:0] error;
   } item_type;

endpackage

/* rtl/spc_front.sv */
// Front stage: takes request transactions, forms the speed error and flags stop items.
module spc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,
   input  logic [spc_pkg::DBOUND_W-1:0] drive_bound,
   output logic                       push_valid,
   input  logic                       push_ready,
   output spc_pkg::item_type          push_item
);

   logic              hold_valid_ff, hold_valid_in;
   spc_pkg::item_type item_ff, item_in;
   logic signed [spc_pkg::SPEED_W-1:0] target;
   logic signed [spc_pkg::SPEED_W-1:0] measured;
   logic accept;

   assign target     = req_tdata[15:0];
   assign measured   = req_tdata[31:16];
   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.stop   = (target == '0) || (drive_bound == '0);
         item_in.target = target;
         item_in.error  = spc_pkg::ERROR_W'(target) - spc_pkg::ERROR_W'(measured);
      end
      if (accept)
         hold_valid_in = 1'b1;
      else if (push_ready)
         hold_valid_in = 1'b0;
      else
         hold_valid_in = hold_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         hold_valid_ff <= 1'b0;
      else
         hold_valid_ff <= hold_valid_in;
      item_ff <= item_in;
   end

endmodule

/* rtl/spc_queue.sv */
// Small register queue between the front stage and the control loop.
module spc_queue #(
   parameter int unsigned DEPTH = spc_pkg::QUEUE_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  spc_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output spc_pkg::item_type pop_item
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   spc_pkg::item_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CntW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

/* rtl/spc_back.sv */
// Control loop: integral update, gain products, rounding, clamping and anti-windup.
module spc_back #(
   parameter int unsigned FRAC_BITS = spc_pkg::FRAC_BITS_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  spc_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop,
   input  spc_pkg::item_type pop_item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [spc_pkg::CMD_W-1:0] drive_cmd,
   output logic              clipped
);

   localparam logic [63:0] FracMask = (64'd1 << FRAC_BITS) - 64'd1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   typedef struct packed {
      logic signed [spc_pkg::CMD_W-1:0] cmd;
      logic hi;
      logic lo;
   } clamp_type;

   // divide by 2^FRAC_BITS toward zero, then clamp to +/- bound
   function automatic clamp_type drive_clamp(input logic signed [63:0] total,
                                             input logic [spc_pkg::DBOUND_W-1:0] bound);
      logic signed [63:0] quot;
      logic signed [63:0] lim;
      clamp_type r;
      quot = total >>> FRAC_BITS;
      if (total[63] && ((total & FracMask) != 64'd0))
         quot = quot + 64'sd1;
      lim  = $signed(64'(bound));
      r.hi = (quot > lim);
      r.lo = (quot < -lim);
      if (r.hi)
         r.cmd = spc_pkg::CMD_W'(lim);
      else if (r.lo)
         r.cmd = spc_pkg::CMD_W'(-lim);
      else
         r.cmd = spc_pkg::CMD_W'(quot);
      return r;
   endfunction

   state_type state_ff, state_in;
   logic signed [spc_pkg::SPEED_W-1:0] target_ff, target_in;
   logic signed [spc_pkg::ERROR_W-1:0] error_ff, error_in;
   logic        stop_ff, stop_in;
   logic signed [spc_pkg::SUM_W-1:0] cand_ff, cand_in;
   logic signed [spc_pkg::SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [63:0] prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic signed [63:0] base_ff, base_in;
   logic signed [63:0] total_new_ff, total_new_in, total_old_ff, total_old_in;
   logic        out_valid_ff, out_valid_in;
   logic [spc_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic        clip_ff, clip_in;

   logic signed [spc_pkg::GAIN_W-1:0] mul_a0, mul_a1;
   logic signed [31:0] mul_b0, mul_b1;
   logic signed [63:0] prod0, prod1;
   logic signed [spc_pkg::SUM_W:0] sum_wide, ibound;
   logic signed [spc_pkg::SUM_W-1:0] cand_next;
   clamp_type res_new, res_old;
   logic out_free, keep_sum;

   assign out_free = !out_valid_ff || rsp_tready;
   assign pop      = (state_ff == ST_IDLE) && pop_valid;

   // first pass uses feedforward and proportional gains, second pass the integral gain
   always_comb begin
      if (state_ff == ST_IDLE) begin
         mul_a0 = cfg.feedfwd_gain;
         mul_b0 = 32'(pop_item.target);
         mul_a1 = cfg.prop_gain;
         mul_b1 = 32'(pop_item.error);
      end else begin
         mul_a0 = cfg.integ_gain;
         mul_b0 = cand_ff;
         mul_a1 = cfg.integ_gain;
         mul_b1 = error_sum_ff;
      end
   end

   assign prod0 = 64'(mul_a0) * 64'(mul_b0);
   assign prod1 = 64'(mul_a1) * 64'(mul_b1);

   // candidate integral, clamped; a zero bound clamps to zero
   always_comb begin
      sum_wide = 33'(error_sum_ff) + 33'(pop_item.error);
      ibound   = $signed({2'b00, cfg.integ_bound});
      if (sum_wide > ibound)
         cand_next = spc_pkg::SUM_W'(ibound);
      else if (sum_wide < -ibound)
         cand_next = spc_pkg::SUM_W'(-ibound);
      else
         cand_next = spc_pkg::SUM_W'(sum_wide);
   end

   assign res_new  = drive_clamp(total_new_ff, cfg.drive_bound);
   assign res_old  = drive_clamp(total_old_ff, cfg.drive_bound);
   assign keep_sum = (res_new.hi && (error_ff >= 0)) || (res_new.lo && (error_ff <= 0));

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      error_in     = error_ff;
      stop_in      = stop_ff;
      cand_in      = cand_ff;
      error_sum_in = error_sum_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      base_in      = base_ff;
      total_new_in = total_new_ff;
      total_old_in = total_old_ff;
      cmd_in       = cmd_ff;
      clip_in      = clip_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               target_in = pop_item.target;
               error_in  = pop_item.error;
               stop_in   = pop_item.stop;
               cand_in   = cand_next;
               prod0_in  = prod0;
               prod1_in  = prod1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            base_in  = prod0_ff + prod1_ff;
            prod0_in = prod0;
            prod1_in = prod1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            total_new_in = base_ff + prod0_ff;
            total_old_in = base_ff + prod1_ff;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (stop_ff) begin
                  error_sum_in = '0;
                  cmd_in       = '0;
                  clip_in      = 1'b0;
               end else if (keep_sum) begin
                  cmd_in  = res_old.cmd;
                  clip_in = res_old.hi || res_old.lo;
               end else begin
                  error_sum_in = cand_ff;
                  cmd_in       = res_new.cmd;
                  clip_in      = res_new.hi || res_new.lo;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         error_sum_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         error_sum_ff <= error_sum_in;
         out_valid_ff <= out_valid_in;
      end
      target_ff    <= target_in;
      error_ff     <= error_in;
      stop_ff      <= stop_in;
      cand_ff      <= cand_in;
      prod0_ff     <= prod0_in;
      prod1_ff     <= prod1_in;
      base_ff      <= base_in;
      total_new_ff <= total_new_in;
      total_old_ff <= total_old_in;
      cmd_ff       <= cmd_in;
      clip_ff      <= clip_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign drive_cmd  = cmd_ff;
   assign clipped    = clip_ff;

endmodule

/* rtl/speed_pi_controller_core.sv */
// Top level of the wheel speed PI controller with feedforward and anti-windup.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------
//  req_    | in  | tdata[15:0] target_speed, tdata[31:16] measured_speed
//  rsp_    | out | tdata[15:0] drive_cmd, tuser[0] clipped
//  csr_    | in  | wen, index 0..4, wdata up to 32 bits
//
// Each transaction passes through the control loop in order: pop, gain products,
// sums, round/clamp/commit; the integral written at the end of one item
// feeds the next, so the loop takes no new transaction before the last one is committed.
// The front stage and queue keep accepting requests while the loop works.
// Synchronous active-high reset clears all gains, bounds and the integral.
// A stalled response holds the loop in its commit step; the queue fills behind it.
module speed_pi_controller_core #(
   parameter int unsigned FRAC_BITS   = spc_pkg::FRAC_BITS_DFLT,
   parameter int unsigned QUEUE_DEPTH = spc_pkg::QUEUE_DEPTH_DFLT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] target_speed, [31:16] measured_speed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] drive_cmd
   output logic [0:0]  rsp_tuser,   // [0] clipped
   input  logic        csr_wen,
   input  logic [spc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   spc_pkg::cfg_type  cfg_ff, cfg_in;
   spc_pkg::item_type push_item, pop_item;
   logic push_valid, push_ready, pop_valid, pop;
   logic clipped;

   // register file; writes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            spc_pkg::CSR_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata;
            spc_pkg::CSR_INTEG_GAIN:   cfg_in.integ_gain   = csr_wdata;
            spc_pkg::CSR_FEEDFWD_GAIN: cfg_in.feedfwd_gain = csr_wdata;
            spc_pkg::CSR_INTEG_BOUND:  cfg_in.integ_bound  = csr_wdata[spc_pkg::IBOUND_W-1:0];
            spc_pkg::CSR_DRIVE_BOUND:  cfg_in.drive_bound  = csr_wdata[spc_pkg::DBOUND_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= '0;
      else
         cfg_ff <= cfg_in;
   end

   spc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .drive_bound (cfg_ff.drive_bound),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   spc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   spc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .drive_cmd  (rsp_tdata),
      .clipped    (clipped)
   );

   assign rsp_tuser = clipped;

`ifndef NO_ASSERTIONS
   // the loop only takes from a queue that holds something
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

   // a clipped command sits exactly on the drive bound
   a_clip_on_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (($signed(rsp_tdata) == $signed(17'(cfg_ff.drive_bound))) ||
          ($signed(rsp_tdata) == -$signed(17'(cfg_ff.drive_bound)))))
      else $error("clipped flag set off the drive bound");

   // a zero drive bound stops the motor without clipping
   a_zero_bound_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (cfg_ff.drive_bound == '0)) |->
         ((rsp_tdata == '0) && !rsp_tuser[0]))
      else $error("nonzero command with zero drive bound");
`endif

endmodule
